// ----- hw/rtl/sbmm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmm_pkg: shared types and constants of the batched matrix multiply
// Field widths, input mode codes and the tag that rides along the MAC pipe.
// ----------------------------------------------------------------------------
package sbmm_pkg;

    // Fixed field widths of the stream words
    localparam int IDX_W     = 2;
    localparam int DIM_W     = 3;
    localparam int VAL_W     = 16;
    localparam int ACC_W     = 34;
    localparam int MODE_W    = 2;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    // Edge length after reset
    localparam logic [DIM_W-1:0] DIM_RESET = 3'd4;

    // Input word kinds carried on s_tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_WR_A    = 2'd0,
        MODE_WR_B    = 2'd1,
        MODE_COMPUTE = 2'd2
    } mode_t;

    // Tag of one product term in flight
    typedef struct packed {
        logic [IDX_W-1:0] x;
        logic [IDX_W-1:0] y;
        logic [IDX_W-1:0] k;
        logic             first_term;
        logic             last_term;
        logic             last_out;
    } mac_tag_t;

endpackage

// ----- hw/rtl/sbmm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sbmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/sbmm_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmm_mac: shared multiply-accumulate unit
// Registers one product per cycle while en is high and folds it into a running sum; the sum
// restarts on the first term of each output element.
// ----------------------------------------------------------------------------
module sbmm_mac #(
    parameter int ELEM_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  sbmm_pkg::mac_tag_t          in_tag,
    input  logic [ELEM_BITS-1:0]        a,
    input  logic [ELEM_BITS-1:0]        b,
    output logic                        out_valid,
    output sbmm_pkg::mac_tag_t          out_tag,
    output logic [sbmm_pkg::ACC_W-1:0]  sum
);

    logic signed [2*ELEM_BITS-1:0]      prod;
    logic signed [sbmm_pkg::ACC_W-1:0]  prod_reg;
    logic [sbmm_pkg::ACC_W-1:0]         acc_reg;
    logic                               valid_reg;
    sbmm_pkg::mac_tag_t                 tag_reg;

    assign prod = $signed(a) * $signed(b);

    // Product stage
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            prod_reg <= sbmm_pkg::ACC_W'(prod);
            tag_reg  <= in_tag;
        end
    end

    // Restart the sum on the first term, otherwise add on
    assign sum = tag_reg.first_term ? prod_reg : acc_reg + prod_reg;

    always_ff @(posedge clk) begin
        if (en && valid_reg) begin
            acc_reg <= sum;
        end
    end

    assign out_valid = valid_reg;
    assign out_tag   = tag_reg;

endmodule

// ----- hw/rtl/slice_batched_matrix_multiply.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slice_batched_matrix_multiply: batched matrix multiply on rank-3 tensors
// Stores elements of A and B; a compute word emits every
// C[x][y][k] = sum_i A[i][y][k] * B[x][i][k], x outermost, k innermost.
// ----------------------------------------------------------------------------
//  channel  | dir | fields (lowest bit up)
//  s_       | in  | tuser: mode; tdata: first_index, second_index,
//           |     |   third_index, element_value
//  m_       | out | tdata: product_value, out_x, out_y, out_k; tlast: is_last
//  cfg_     | in  | wdata: dim_in_use
//
// A compute word with edge length D issues D^4 terms into the single
// multiply-accumulate unit, one term per cycle while the m_ side does not
// stall; each result passes the read stage, the product register and the
// output register. s_tready is low while terms issue. A stalled m_ side
// freezes the whole MAC pipe. Reset is synchronous, active low, and clears
// control state only; the tensor stores are not cleared.
// ----------------------------------------------------------------------------
module slice_batched_matrix_multiply #(
    parameter int MAX_DIM   = 4,
    parameter int ELEM_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: first_index, second_index, third_index, element_value, pad
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sbmm_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: mode
    input  logic [sbmm_pkg::MODE_W-1:0]        s_tuser,
    // m_tdata: product_value, out_x, out_y, out_k
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sbmm_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast,
    input  logic                               cfg_we,
    input  logic [sbmm_pkg::DIM_W-1:0]         cfg_wdata
);

    localparam int CELLS  = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int IW     = sbmm_pkg::IDX_W;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [IW-1:0] f,
        input logic [IW-1:0] s,
        input logic [IW-1:0] t
    );
        cell_addr = ADDR_W'((int'(f) * MAX_DIM + int'(s)) * MAX_DIM + int'(t));
    endfunction

    state_t                          state_reg;
    logic [sbmm_pkg::DIM_W-1:0]      dim_reg;
    logic [IW-1:0]                   dlast_reg;
    logic [IW-1:0]                   x_reg, y_reg, k_reg, i_reg;
    logic [IW-1:0]                   x_next, y_next, k_next, i_next;
    logic                            s1_valid_reg;
    sbmm_pkg::mac_tag_t              s1_tag_reg;

    logic                            s_acc;
    sbmm_pkg::mode_t                 s_mode;
    logic [IW-1:0]                   s_f, s_s, s_t;
    logic signed [sbmm_pkg::VAL_W-1:0] s_elem;
    logic                            idx_ok;
    logic [sbmm_pkg::DIM_W-1:0]      dim_m1;
    logic [IW-1:0]                   dlast_new;
    logic                            adv, issue, done;
    logic                            we_a, we_b;
    logic [ADDR_W-1:0]               waddr, raddr_a, raddr_b;
    logic [ELEM_BITS-1:0]            wdata, rdata_a, rdata_b;
    sbmm_pkg::mac_tag_t              issue_tag;

    logic                            mac_valid;
    sbmm_pkg::mac_tag_t              mac_tag;
    logic [sbmm_pkg::ACC_W-1:0]      mac_sum;
    logic                            out_load;

    logic                            m_valid_reg;
    logic [sbmm_pkg::ACC_W-1:0]      m_prod_reg;
    logic [IW-1:0]                   m_x_reg, m_y_reg, m_k_reg;
    logic                            m_last_reg;

    // Unpack the input word
    assign s_mode = sbmm_pkg::mode_t'(s_tuser);
    assign s_f    = s_tdata[1:0];
    assign s_s    = s_tdata[3:2];
    assign s_t    = s_tdata[5:4];
    assign s_elem = s_tdata[21:6];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // Clamp the edge length into 1..MAX_DIM, kept as D-1
    assign dim_m1 = dim_reg - 3'd1;
    always_comb begin
        if (dim_reg == '0) begin
            dlast_new = '0;
        end else if (int'(dim_reg) > MAX_DIM) begin
            dlast_new = IW'(MAX_DIM - 1);
        end else begin
            dlast_new = dim_m1[IW-1:0];
        end
    end

    // Element writes
    assign idx_ok = (int'(s_f) < MAX_DIM) && (int'(s_s) < MAX_DIM) && (int'(s_t) < MAX_DIM);
    assign we_a   = s_acc && (s_mode == sbmm_pkg::MODE_WR_A) && idx_ok;
    assign we_b   = s_acc && (s_mode == sbmm_pkg::MODE_WR_B) && idx_ok;
    assign waddr  = cell_addr(s_f, s_s, s_t);
    assign wdata  = ELEM_BITS'(s_elem);

    // Pipe advances whenever the output register can take a word
    assign adv   = !m_valid_reg || m_tready;
    assign issue = (state_reg == ST_RUN) && adv;

    // Term counters, i innermost
    assign done = (x_reg == dlast_reg) && (y_reg == dlast_reg)
                  && (k_reg == dlast_reg) && (i_reg == dlast_reg);
    always_comb begin
        i_next = i_reg + 1'b1;
        k_next = k_reg;
        y_next = y_reg;
        x_next = x_reg;
        if (i_reg == dlast_reg) begin
            i_next = '0;
            k_next = k_reg + 1'b1;
            if (k_reg == dlast_reg) begin
                k_next = '0;
                y_next = y_reg + 1'b1;
                if (y_reg == dlast_reg) begin
                    y_next = '0;
                    x_next = x_reg + 1'b1;
                end
            end
        end
    end

    assign raddr_a = cell_addr(i_reg, y_reg, k_reg);
    assign raddr_b = cell_addr(x_reg, i_reg, k_reg);

    always_comb begin
        issue_tag.x          = x_reg;
        issue_tag.y          = y_reg;
        issue_tag.k          = k_reg;
        issue_tag.first_term = (i_reg == '0);
        issue_tag.last_term  = (i_reg == dlast_reg);
        issue_tag.last_out   = done;
    end

    // Sequencer: state, config register, counters and read stage tag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            dim_reg      <= sbmm_pkg::DIM_RESET;
            s1_valid_reg <= 1'b0;
            x_reg        <= '0;
            y_reg        <= '0;
            k_reg        <= '0;
            i_reg        <= '0;
            dlast_reg    <= '0;
        end else begin
            if (cfg_we) begin
                dim_reg <= cfg_wdata;
            end
            if (adv) begin
                s1_valid_reg <= issue;
            end
            if (issue) begin
                s1_tag_reg <= issue_tag;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc && s_mode == sbmm_pkg::MODE_COMPUTE) begin
                        state_reg <= ST_RUN;
                        dlast_reg <= dlast_new;
                        x_reg     <= '0;
                        y_reg     <= '0;
                        k_reg     <= '0;
                        i_reg     <= '0;
                    end
                end
                ST_RUN: begin
                    if (adv) begin
                        x_reg <= x_next;
                        y_reg <= y_next;
                        k_reg <= k_next;
                        i_reg <= i_next;
                        if (done) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    sbmm_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (CELLS),
        .AW    (ADDR_W)
    ) u_store_a (
        .clk   (aclk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .re    (issue),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    sbmm_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (CELLS),
        .AW    (ADDR_W)
    ) u_store_b (
        .clk   (aclk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata),
        .re    (issue),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    sbmm_mac #(
        .ELEM_BITS (ELEM_BITS)
    ) u_mac (
        .clk       (aclk),
        .rst_n     (aresetn),
        .en        (adv),
        .in_valid  (s1_valid_reg),
        .in_tag    (s1_tag_reg),
        .a         (rdata_a),
        .b         (rdata_b),
        .out_valid (mac_valid),
        .out_tag   (mac_tag),
        .sum       (mac_sum)
    );

    // Output register: load a finished sum, drop it once taken
    assign out_load = adv && mac_valid && mac_tag.last_term;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_prod_reg <= mac_sum;
            m_x_reg    <= mac_tag.x;
            m_y_reg    <= mac_tag.y;
            m_k_reg    <= mac_tag.k;
            m_last_reg <= mac_tag.last_out;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_k_reg, m_y_reg, m_x_reg, m_prod_reg};
    assign m_tlast  = m_last_reg;

    // The final word of a run sits on the diagonal corner
    a_last_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_x_reg == m_y_reg) && (m_y_reg == m_k_reg))
        else $error("last word not at the corner element");

    // A term only enters the read stage from an issuing sequencer
    a_read_from_run: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !$past(s1_valid_reg) |-> $past(state_reg == ST_RUN))
        else $error("read stage filled while not issuing");

    // A finished sum is never written over a waiting word
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |=> !$past(out_load))
        else $error("output word overwritten while stalled");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

// ----- test/sbmm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmm_checker: result predictor and scoreboard for the batched matmul
// Mirrors both tensor stores and the edge length from the accepted input
// and config words, and expands each compute word into its expected C words.
// It then checks every result word against the oldest expected one.
// ----------------------------------------------------------------------------
module sbmm_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [sbmm_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [sbmm_pkg::MODE_W-1:0]    s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [sbmm_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [sbmm_pkg::DIM_W-1:0]     cfg_wdata,
    output int                             errors,
    output int                             outstanding
);

    localparam int CELLS = 64;

    typedef struct packed {
        logic [sbmm_pkg::ACC_W-1:0] sum;
        logic [sbmm_pkg::IDX_W-1:0] x;
        logic [sbmm_pkg::IDX_W-1:0] y;
        logic [sbmm_pkg::IDX_W-1:0] k;
        logic                       last;
    } c_elem_t;

    logic signed [sbmm_pkg::VAL_W-1:0] tensor_a [CELLS];
    logic signed [sbmm_pkg::VAL_W-1:0] tensor_b [CELLS];
    logic [sbmm_pkg::DIM_W-1:0]        edge_len;
    c_elem_t                           c_expected [$];
    c_elem_t                           c_head;
    c_elem_t                           c_got;
    logic [5:0]                        wr_cell;
    logic [sbmm_pkg::VAL_W-1:0]        wr_value;

    // Input word fields, first_index lowest; cell is (f * 4 + s) * 4 + t
    assign wr_cell  = {s_tdata[1:0], s_tdata[3:2], s_tdata[5:4]};
    assign wr_value = s_tdata[21:6];

    // Result word fields, product_value lowest
    assign c_got = {m_tdata[33:0], m_tdata[35:34], m_tdata[37:36], m_tdata[39:38], m_tlast};

    // Expand one compute word: x outermost, k innermost, sum over i < D
    task automatic queue_products();
        int                 d;
        logic signed [63:0] acc;
        c_elem_t            e;
        d = (edge_len == 0) ? 1 : ((edge_len > 4) ? 4 : int'(edge_len));
        for (int x = 0; x < d; x++) begin
            for (int y = 0; y < d; y++) begin
                for (int k = 0; k < d; k++) begin
                    acc = '0;
                    for (int i = 0; i < d; i++) begin
                        acc = acc + tensor_a[(i * 4 + y) * 4 + k]
                                  * tensor_b[(x * 4 + i) * 4 + k];
                    end
                    e.sum  = acc[sbmm_pkg::ACC_W-1:0];
                    e.x    = x[sbmm_pkg::IDX_W-1:0];
                    e.y    = y[sbmm_pkg::IDX_W-1:0];
                    e.k    = k[sbmm_pkg::IDX_W-1:0];
                    e.last = (x == d - 1) && (y == d - 1) && (k == d - 1);
                    c_expected.insert(c_expected.size(), e);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            edge_len    <= sbmm_pkg::DIM_RESET;
            errors      <= 0;
            outstanding <= 0;
            c_expected.delete();
        end else begin
            if (cfg_we) begin
                edge_len <= cfg_wdata;
            end

            // Track stores and predict on compute
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    sbmm_pkg::MODE_WR_A:    tensor_a[wr_cell] <= wr_value;
                    sbmm_pkg::MODE_WR_B:    tensor_b[wr_cell] <= wr_value;
                    sbmm_pkg::MODE_COMPUTE: queue_products();
                    default: ;
                endcase
            end

            // Compare each result word with the oldest expected word
            if (m_tvalid && m_tready) begin
                if (c_expected.size() == 0) begin
                    if (errors < 10) begin
                        $display("%0t: unexpected C[%0d][%0d][%0d] = %0d last %0b",
                                 $time, c_got.x, c_got.y, c_got.k,
                                 $signed(c_got.sum), c_got.last);
                    end
                    errors <= errors + 1;
                end else begin
                    c_head = c_expected.pop_front();
                    if (c_head != c_got) begin
                        if (errors < 10) begin
                            $display({"%0t: expected C[%0d][%0d][%0d] = %0d last %0b,",
                                      " got C[%0d][%0d][%0d] = %0d last %0b"},
                                     $time, c_head.x, c_head.y, c_head.k,
                                     $signed(c_head.sum), c_head.last,
                                     c_got.x, c_got.y, c_got.k,
                                     $signed(c_got.sum), c_got.last);
                        end
                        errors <= errors + 1;
                    end
                end
            end

            outstanding <= c_expected.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the batched matrix multiply
// Loads elements of A and B, switches the edge length between phases and
// fires compute words, with random gaps and backpressure; the checker beside
// the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [sbmm_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TARGET_WORDS   = 280;
    localparam logic [sbmm_pkg::VAL_W-1:0] VAL_MIN = 16'h8000;
    localparam logic [sbmm_pkg::VAL_W-1:0] VAL_MAX = 16'h7fff;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [sbmm_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic [sbmm_pkg::MODE_W-1:0]    s_tuser   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [sbmm_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tlast;
    logic                           cfg_we    = 1'b0;
    logic [sbmm_pkg::DIM_W-1:0]     cfg_wdata = sbmm_pkg::DIM_RESET;

    int         errors;
    int         outstanding;
    int         quiet_cycles = 0;
    int         stall_left   = 0;
    int         words_sent   = 0;
    int         ready_roll;
    bit         calm         = 1'b0;
    bit         written_a [64];
    bit         written_b [64];
    logic [sbmm_pkg::DIM_W-1:0] cur_dim = sbmm_pkg::DIM_RESET;

    slice_batched_matrix_multiply uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    sbmm_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Stall the result side: mostly ready, short holds, now and then a long one
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 75) begin
                m_tready <= 1'b1;
            end else begin
                m_tready   <= 1'b0;
                stall_left <= (ready_roll < 95) ? $urandom_range(0, 2)
                                                : $urandom_range(9, 39);
            end
        end
    end

    // Abort when no word moves on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("slice_batched_matrix_multiply test failed");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) begin
            return 0;
        end
        return (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    // Bias element values toward the extremes, zero and minus one
    function automatic logic [sbmm_pkg::VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return VAL_MIN;
        if (r < 20) return VAL_MAX;
        if (r < 25) return '0;
        if (r < 30) return '1;
        return sbmm_pkg::VAL_W'($urandom_range(0, 65535));
    endfunction

    function automatic int eff_dim(logic [sbmm_pkg::DIM_W-1:0] v);
        return (v == 0) ? 1 : ((v > 4) ? 4 : int'(v));
    endfunction

    // Present one input word after a random gap and hold it until accepted
    task automatic send_word(input logic [sbmm_pkg::MODE_W-1:0] mode, input int f, s, t,
                             input logic [sbmm_pkg::VAL_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {2'b00, v, t[1:0], s[1:0], f[1:0]};
        do @(posedge aclk); while (!s_tready);
        if (mode == sbmm_pkg::MODE_WR_A) begin
            written_a[(f * 4 + s) * 4 + t] = 1'b1;
        end else if (mode == sbmm_pkg::MODE_WR_B) begin
            written_b[(f * 4 + s) * 4 + t] = 1'b1;
        end
        if (mode != MODE_UNUSED) begin
            words_sent++;
        end
    endtask

    task automatic send_random(input logic [sbmm_pkg::MODE_W-1:0] mode);
        send_word(mode, $urandom_range(0, 3), $urandom_range(0, 3),
                  $urandom_range(0, 3), pick_value());
    endtask

    // Load every element in range that was never written, then compute
    task automatic run_compute();
        int d;
        d = eff_dim(cur_dim);
        for (int f = 0; f < d; f++) begin
            for (int s = 0; s < d; s++) begin
                for (int t = 0; t < d; t++) begin
                    if (!written_a[(f * 4 + s) * 4 + t]) begin
                        send_word(sbmm_pkg::MODE_WR_A, f, s, t, pick_value());
                    end
                    if (!written_b[(f * 4 + s) * 4 + t]) begin
                        send_word(sbmm_pkg::MODE_WR_B, f, s, t, pick_value());
                    end
                end
            end
        end
        send_random(sbmm_pkg::MODE_COMPUTE);
    endtask

    // Drop valid and wait until every expected result word has drained
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_dim(input logic [sbmm_pkg::DIM_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        cur_dim    = v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [sbmm_pkg::DIM_W-1:0] phase_dims [10];
        int               phase;
        int               steps;
        int               roll;
        int               px, py, pk;
        bit               extremes_done;

        phase_dims    = '{3'd2, 3'd3, 3'd7, 3'd1, 3'd4, 3'd5, 3'd2, 3'd6, 3'd3, 3'd4};
        phase         = 0;
        extremes_done = 1'b0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: single-element tensors, value extremes, unused mode
        set_dim(3'd1);
        send_word(sbmm_pkg::MODE_WR_A, 0, 0, 0, VAL_MIN);
        send_word(sbmm_pkg::MODE_WR_B, 0, 0, 0, VAL_MIN);
        send_random(sbmm_pkg::MODE_COMPUTE);
        send_word(sbmm_pkg::MODE_WR_B, 0, 0, 0, VAL_MAX);
        send_random(sbmm_pkg::MODE_COMPUTE);
        send_word(MODE_UNUSED, 0, 0, 0, '1);
        send_word(MODE_UNUSED, 3, 3, 3, VAL_MIN);
        // Store beyond the current edge length must not touch the result
        send_word(sbmm_pkg::MODE_WR_A, 3, 3, 3, VAL_MAX);
        send_word(sbmm_pkg::MODE_WR_B, 3, 3, 3, VAL_MIN);
        send_random(sbmm_pkg::MODE_COMPUTE);
        send_word(sbmm_pkg::MODE_WR_A, 0, 0, 0, '0);
        send_random(sbmm_pkg::MODE_COMPUTE);
        // Edge length zero acts as one
        set_dim(3'd0);
        send_word(sbmm_pkg::MODE_WR_A, 0, 0, 0, VAL_MAX);
        send_word(sbmm_pkg::MODE_WR_B, 0, 0, 0, VAL_MAX);
        send_random(sbmm_pkg::MODE_COMPUTE);

        // Random phases, each under its own edge length
        while (words_sent < TARGET_WORDS) begin
            set_dim(phase_dims[phase % 10]);
            calm <= (phase % 4 == 2);
            steps = $urandom_range(10, 24);
            repeat (steps) begin
                roll = $urandom_range(0, 99);
                if (roll < 6) begin
                    send_random(MODE_UNUSED);
                end else if (roll < 20) begin
                    run_compute();
                end else begin
                    send_random(roll[0] ? sbmm_pkg::MODE_WR_B : sbmm_pkg::MODE_WR_A);
                end
            end

            // Push one full-size sum to both ends of the product range
            if (eff_dim(cur_dim) == 4 && !extremes_done) begin
                px = $urandom_range(0, 3);
                py = $urandom_range(0, 3);
                pk = $urandom_range(0, 3);
                for (int i = 0; i < 4; i++) begin
                    send_word(sbmm_pkg::MODE_WR_A, i, py, pk, VAL_MIN);
                    send_word(sbmm_pkg::MODE_WR_B, px, i, pk, VAL_MIN);
                end
                run_compute();
                for (int i = 0; i < 4; i++) begin
                    send_word(sbmm_pkg::MODE_WR_B, px, i, pk, VAL_MAX);
                end
                run_compute();
                extremes_done = 1'b1;
            end

            run_compute();
            phase++;
        end

        settle();
        if (errors == 0 && outstanding == 0) begin
            $display("slice_batched_matrix_multiply test passed");
        end else begin
            $display("slice_batched_matrix_multiply test failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/sbmm_pkg.sv
hw/rtl/sbmm_ram.sv
hw/rtl/sbmm_mac.sv
hw/rtl/slice_batched_matrix_multiply.sv
test/sbmm_checker.sv
test/tb_top.sv
